>>> hw/rtl/croq_pkg.sv
// Package for the card report overwrite queue.
// Entry layout, record byte positions, operation codes and state type.
// No dependencies.
package croq_pkg;

    localparam int CODE_BITS    = 64;
    localparam int BYTE_BITS    = 8;
    localparam int HEADER_BYTES = 4;
    localparam int BITS_W       = 7;
    localparam int BYTE_CNT_W   = 4;

    // Operation codes carried on func
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Record byte positions of the header
    localparam logic [BYTE_CNT_W-1:0] POS_READER = 4'd0;
    localparam logic [BYTE_CNT_W-1:0] POS_FORMAT = 4'd1;
    localparam logic [BYTE_CNT_W-1:0] POS_BITS   = 4'd2;
    localparam logic [BYTE_CNT_W-1:0] POS_ZERO   = 4'd3;

    // One stored card read: 80 bits
    typedef struct packed {
        logic [7:0]           reader;
        logic                 format;
        logic [BITS_W-1:0]    bits;
        logic [CODE_BITS-1:0] code;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

endpackage

>>> hw/rtl/croq_if.sv
// Handshake channels of the card report overwrite queue.
// Command channel (push/pop) and record byte channel. No dependencies.
interface croq_cmd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  reader_number;
    logic        card_format;
    logic [6:0]  bit_count;
    logic [63:0] card_code;

    modport source (output valid, func, reader_number, card_format, bit_count, card_code,
                    input ready);
    modport sink   (input valid, func, reader_number, card_format, bit_count, card_code,
                    output ready);
endinterface

interface croq_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       queue_empty;
    logic       last_byte;

    modport source (output valid, record_byte, queue_empty, last_byte, input ready);
    modport sink   (input valid, record_byte, queue_empty, last_byte, output ready);
endinterface

>>> hw/rtl/card_report_overwrite_queue_core.sv
// Card report overwrite queue: ring of card reads, oldest dropped when full.
// Push: writes the entry, no result. Pop: entry read from memory into a register at accept,
// then record bytes from the output register, one byte per cycle while the output is not stalled;
// a pop holds the command channel (not ready) until the last record byte (1 to 12) is loaded.
// Reset (async, active low) clears indices and control; memory is not cleared.
// Depends on croq_pkg and croq_if.
module card_report_overwrite_queue_core
    import croq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    croq_cmd_if.sink     cmd,
    croq_rec_if.source   rec
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    entry_t mem [QUEUE_DEPTH];

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [BYTE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   empty_reg, empty_next;
    logic                   out_valid_reg, out_valid_next;
    entry_t                 rd_data_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_empty_reg;
    logic                   out_last_reg;

    logic                   cmd_fire;
    logic                   push;
    logic                   pop;
    logic                   queue_is_empty;
    logic [IDX_W-1:0]       wr_idx_inc;
    logic [IDX_W-1:0]       rd_idx_inc;
    logic [BITS_W-1:0]      bits_sat;
    entry_t                 wr_entry;
    logic                   load;
    logic [BYTE_CNT_W-1:0]  total;
    logic                   byte_last;
    logic [7:0]             byte_val;
    logic [2:0]             code_n;

    // Command decode
    assign cmd_fire       = cmd.valid && cmd.ready;
    assign push           = cmd_fire && (cmd.func == FUNC_PUSH);
    assign pop            = cmd_fire && (cmd.func == FUNC_POP);
    assign queue_is_empty = (rd_idx_reg == wr_idx_reg);
    assign wr_idx_inc     = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc     = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;

    // Saturate bit count and pack the entry
    assign bits_sat = (cmd.bit_count > BITS_W'(CODE_BITS)) ? BITS_W'(CODE_BITS)
                                                           : cmd.bit_count;
    always_comb
    begin
        wr_entry.reader = cmd.reader_number;
        wr_entry.format = cmd.card_format;
        wr_entry.bits   = bits_sat;
        wr_entry.code   = cmd.card_code;
    end

    // Entry memory: write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_idx_reg] <= wr_entry;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Record length and current byte
    assign total     = BYTE_CNT_W'(HEADER_BYTES)
                     + BYTE_CNT_W'(7'(rd_data_reg.bits + 7'd7) >> 3);
    assign byte_last = empty_reg || ((cnt_reg + 1'b1) == total);
    assign code_n    = cnt_reg[2:0] - 3'(HEADER_BYTES);

    always_comb
    begin
        case (cnt_reg)
            POS_READER: byte_val = rd_data_reg.reader;
            POS_FORMAT: byte_val = {7'd0, rd_data_reg.format};
            POS_BITS:   byte_val = {1'b0, rd_data_reg.bits};
            POS_ZERO:   byte_val = 8'd0;
            default:    byte_val = rd_data_reg.code[{~code_n, 3'b000} +: BYTE_BITS];
        endcase
        if (empty_reg)
        begin
            byte_val = 8'd0;
        end
    end

    assign load = (state_reg == ST_STREAM) && (!out_valid_reg || rec.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (load && byte_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        cnt_next       = cnt_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        cmd.ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (push)
                begin
                    wr_idx_next = wr_idx_inc;
                    if (wr_idx_inc == rd_idx_reg)
                    begin
                        rd_idx_next = rd_idx_inc;
                    end
                end
                if (pop)
                begin
                    cnt_next   = '0;
                    empty_next = queue_is_empty;
                    if (!queue_is_empty)
                    begin
                        rd_idx_next = rd_idx_inc;
                    end
                end
            end
            ST_STREAM:
            begin
                if (load)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rec.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            cnt_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            cnt_reg       <= cnt_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= byte_val;
            out_empty_reg <= empty_reg;
            out_last_reg  <= byte_last;
        end
    end

    assign rec.valid       = out_valid_reg;
    assign rec.record_byte = out_byte_reg;
    assign rec.queue_empty = out_empty_reg;
    assign rec.last_byte   = out_last_reg;

    // Checks
    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (rd_idx_reg != wr_idx_reg))
        else $error("queue empty after push");

    a_no_cmd_while_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |-> !cmd.ready)
        else $error("command taken during record stream");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rec.valid && rec.queue_empty) |-> rec.last_byte)
        else $error("empty result without last flag");

    a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (load && byte_last) |=> (state_reg == ST_IDLE))
        else $error("stream did not end after last byte");

endmodule

>>> sim/tb_card_report_overwrite_queue_core.sv
// Testbench for card_report_overwrite_queue_core: push/pop commands against a shadow ring,
// with record bytes checked in order. Depends on croq_pkg, croq_if and the core RTL.
`timescale 1ns / 100ps

module tb_card_report_overwrite_queue_core;
    import croq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int RAND_ITEMS  = 240;
    localparam int IDLE_PCT    = 34;
    // Worst run: ~280 items, each stretched by stalls; the limit is many times that
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic        func;
        logic [7:0]  reader;
        logic        fmt;
        logic [6:0]  bits;
        logic [63:0] code;
        bit          hold;   // wait for all record bytes before presenting
    } card_cmd_t;

    typedef struct {
        logic [7:0] data;
        logic       empty;
        logic       last;
    } rec_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    croq_cmd_if cmd_ch();
    croq_rec_if rec_ch();

    card_report_overwrite_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rec   (rec_ch)
    );

    always #4 clk = ~clk;

    card_cmd_t cmds_pending[$];
    rec_beat_t record_bytes_due[$];

    // Shadow of the ring and its indices
    entry_t shadow_ring [QUEUE_DEPTH];
    int     wr_ptr = 0;
    int     rd_ptr = 0;

    int  accepted_cnt = 0;
    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    logic steady;

    // No idling on either side while this window of commands goes through
    assign steady = (accepted_cnt >= 100) && (accepted_cnt < 150);

    // Apply one accepted command to the shadow ring, queue the record bytes it yields
    task automatic ring_apply(input card_cmd_t c);
        entry_t      e;
        rec_beat_t   r;
        logic [6:0]  sat_bits;
        int          total;
        begin
            if (c.func == FUNC_PUSH) begin
                sat_bits = (c.bits > 7'(CODE_BITS)) ? 7'(CODE_BITS) : c.bits;
                e.reader = c.reader;
                e.format = c.fmt;
                e.bits   = sat_bits;
                e.code   = c.code;
                shadow_ring[wr_ptr] = e;
                wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
                // full ring: oldest entry goes
                if (wr_ptr == rd_ptr)
                    rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            end
            else if (rd_ptr == wr_ptr) begin
                r.data  = 8'h00;
                r.empty = 1'b1;
                r.last  = 1'b1;
                record_bytes_due.push_back(r);
            end
            else begin
                e = shadow_ring[rd_ptr];
                total = HEADER_BYTES + (int'(e.bits) + BYTE_BITS - 1) / BYTE_BITS;
                for (int k = 0; k < total; k++) begin
                    if (k == int'(POS_READER))
                        r.data = e.reader;
                    else if (k == int'(POS_FORMAT))
                        r.data = {7'd0, e.format};
                    else if (k == int'(POS_BITS))
                        r.data = {1'b0, e.bits};
                    else if (k == int'(POS_ZERO))
                        r.data = 8'h00;
                    else
                        r.data = e.code[CODE_BITS - 1 - BYTE_BITS * (k - HEADER_BYTES) -: 8];
                    r.empty = 1'b0;
                    r.last  = (k == total - 1);
                    record_bytes_due.push_back(r);
                end
                rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            end
        end
    endtask

    task automatic add_cmd(input logic func, input logic [7:0] reader, input logic fmt,
                           input logic [6:0] bits, input logic [63:0] code, input bit hold);
        card_cmd_t c;
        begin
            c.func   = func;
            c.reader = reader;
            c.fmt    = fmt;
            c.bits   = bits;
            c.code   = code;
            c.hold   = hold;
            cmds_pending.push_back(c);
        end
    endtask

    // Random content; mostly legal bit counts, some above the saturation point
    task automatic add_random(input logic func, input bit hold);
        logic [6:0] bits;
        begin
            bits = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(CODE_BITS));
            add_cmd(func, 8'($urandom_range(255)), 1'($urandom_range(1)), bits,
                    {$urandom, $urandom}, hold);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        begin
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatch_cnt++;
            end
        end
    endtask

    // Command driver: holds an item until taken, idles at random between items
    always @(posedge clk) begin
        bit go;
        if (rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                ring_apply(cmds_pending.pop_front());
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                go = (cmds_pending.size() != 0);
                if (go && cmds_pending[0].hold && record_bytes_due.size() != 0)
                    go = 1'b0;
                if (go && !steady && $urandom_range(99) < IDLE_PCT)
                    go = 1'b0;
                if (go) begin
                    cmd_ch.func          <= cmds_pending[0].func;
                    cmd_ch.reader_number <= cmds_pending[0].reader;
                    cmd_ch.card_format   <= cmds_pending[0].fmt;
                    cmd_ch.bit_count     <= cmds_pending[0].bits;
                    cmd_ch.card_code     <= cmds_pending[0].code;
                end
                cmd_ch.valid <= go;
            end
        end
    end

    // Record monitor: checks each taken byte against the oldest expectation
    always @(posedge clk) begin
        rec_beat_t want;
        if (rst_n) begin
            if (rec_ch.valid && rec_ch.ready) begin
                if (record_bytes_due.size() == 0) begin
                    $display("%0t: unexpected record byte, expected none, got %0h empty %0b last %0b",
                             $time, rec_ch.record_byte, rec_ch.queue_empty, rec_ch.last_byte);
                    mismatch_cnt++;
                end
                else begin
                    want = record_bytes_due.pop_front();
                    check_field("record_byte", want.data, rec_ch.record_byte);
                    check_field("queue_empty", {7'd0, want.empty}, {7'd0, rec_ch.queue_empty});
                    check_field("last_byte", {7'd0, want.last}, {7'd0, rec_ch.last_byte});
                end
            end
            rec_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("card_report_overwrite_queue_core verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int  n_rand;
        int  len;
        int  pop_pct;
        bit  burst_done;

        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.func          = FUNC_PUSH;
        cmd_ch.reader_number = 8'h00;
        cmd_ch.card_format   = 1'b0;
        cmd_ch.bit_count     = 7'd0;
        cmd_ch.card_code     = 64'd0;
        rec_ch.ready         = 1'b0;
        n_rand               = 0;
        burst_done           = 1'b0;

        // Directed: pop on empty, zero-length code, extremes, saturation, byte boundaries
        add_cmd(FUNC_POP, 8'h00, 1'b0, 7'd0, 64'd0, 1'b0);
        add_cmd(FUNC_PUSH, 8'h00, 1'b0, 7'd0, 64'd0, 1'b0);
        add_cmd(FUNC_POP, 8'hFF, 1'b1, 7'h7F, '1, 1'b0);
        add_cmd(FUNC_PUSH, 8'hFF, 1'b1, 7'd64, '1, 1'b0);
        add_cmd(FUNC_PUSH, 8'h5A, 1'b0, 7'h7F, 64'h0123_4567_89AB_CDEF, 1'b0);
        add_cmd(FUNC_PUSH, 8'hA5, 1'b1, 7'd65, 64'h8000_0000_0000_0001, 1'b0);
        add_cmd(FUNC_PUSH, 8'h01, 1'b0, 7'd1, 64'h8000_0000_0000_0000, 1'b0);
        add_cmd(FUNC_PUSH, 8'h02, 1'b1, 7'd8, 64'hFEDC_BA98_7654_3210, 1'b0);
        add_cmd(FUNC_PUSH, 8'h03, 1'b0, 7'd9, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_cmd(FUNC_PUSH, 8'h04, 1'b1, 7'd63, {$urandom, $urandom}, 1'b0);
        add_cmd(FUNC_PUSH, 8'h80, 1'b0, 7'd26, 64'hC0FF_EE00_0000_0000, 1'b0);
        for (int i = 0; i < 9; i++)
            add_cmd(FUNC_POP, 8'(i), 1'(i), 7'(i * 13), {$urandom, $urandom}, 1'b0);

        // Random: groups biased to fill, drain or mix; one overflow burst
        while (n_rand < RAND_ITEMS) begin
            if (!burst_done && n_rand >= 120) begin
                for (int i = 0; i < 20; i++)
                    add_random(FUNC_PUSH, 1'b0);
                for (int i = 0; i < 17; i++)
                    add_random(FUNC_POP, i == 4);
                n_rand += 37;
                burst_done = 1'b1;
            end
            else begin
                len = $urandom_range(20, 8);
                case ($urandom_range(2))
                    0:       pop_pct = 50;
                    1:       pop_pct = 20;
                    default: pop_pct = 80;
                endcase
                for (int i = 0; i < len; i++)
                    add_random(($urandom_range(99) < pop_pct) ? FUNC_POP : FUNC_PUSH,
                               $urandom_range(39) == 0);
                n_rand += len;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_pending.size() != 0 || record_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && record_bytes_due.size() == 0)
            $display("card_report_overwrite_queue_core verification clean");
        else
            $display("card_report_overwrite_queue_core verification failed");
        $finish;
    end

endmodule
